// File: sv/swwf_pkg.sv
// ============================================================================
// swwf_pkg
// Shared types and constants for the 3x3 side-window weighted filter.
// ============================================================================
`default_nettype none

package swwf_pkg;

  localparam int PIX_W    = 8;
  localparam int NUM_WIN  = 8;
  localparam int WIN_W    = 3;
  // Largest weighted sum is 12 * 255 = 3060, which fits in 12 bits.
  localparam int SUM_W    = 12;

  // Reciprocal constants: avg = (sum * RECIP) >> DIV_SHIFT, exact for sum < 4096.
  localparam int DIV_SHIFT = 16;
  localparam int RECIP_W   = 13;
  localparam logic [RECIP_W-1:0] RECIP_QUAD = RECIP_W'(7282);  // ceil(2^16 / 9)
  localparam logic [RECIP_W-1:0] RECIP_HALF = RECIP_W'(5462);  // ceil(2^16 / 12)

  // Windows 0..3 are quadrants (total 9), 4..7 are halves (total 12).
  localparam int NUM_QUAD = 4;

  typedef logic [SUM_W-1:0] sum_arr_t [NUM_WIN];
  typedef logic [PIX_W-1:0] avg_arr_t [NUM_WIN];

endpackage

`default_nettype wire

// File: sv/side_window_weighted_filter_3x3_core.sv
// ============================================================================
// side_window_weighted_filter_3x3_core
// Five-stage pipeline: weighted sums, averages, distances to the centre,
// pairwise pick of the closest window, final pick with border bypass.
// ============================================================================
// Throughput: one transaction per cycle while out_ready is high; every stage
//   has its own valid bit and takes new data whenever it is empty or its
//   successor takes its data.
// Reset: rst (synchronous) clears all stage valid bits; data registers
//   are not reset.
`default_nettype none

module side_window_weighted_filter_3x3_core
  import swwf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] px_up_left,
  input  wire logic [PIX_W-1:0] px_up,
  input  wire logic [PIX_W-1:0] px_up_right,
  input  wire logic [PIX_W-1:0] px_left,
  input  wire logic [PIX_W-1:0] px_center,
  input  wire logic [PIX_W-1:0] px_right,
  input  wire logic [PIX_W-1:0] px_down_left,
  input  wire logic [PIX_W-1:0] px_down,
  input  wire logic [PIX_W-1:0] px_down_right,
  input  wire logic             on_border,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [PIX_W-1:0]      filtered_pixel,
  output logic [WIN_W-1:0]      chosen_window
);

  localparam int NUM_PAIR = NUM_WIN / 2;

  typedef struct packed {
    logic [PIX_W-1:0] diff;
    logic [PIX_W-1:0] avg;
    logic [WIN_W-1:0] idx;
  } cand_t;

  // Stage valid bits and per-stage ready
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  // Stage data
  sum_arr_t         s1_sum;
  logic [PIX_W-1:0] s1_center, s2_center, s3_center, s4_center;
  logic             s1_border, s2_border, s3_border, s4_border;
  avg_arr_t         s2_avg, s3_avg;
  avg_arr_t         s3_dist;
  cand_t            s4_cand [NUM_PAIR];
  logic [PIX_W-1:0] s5_pixel;
  logic [WIN_W-1:0] s5_window;

  // Combinational values feeding each register stage
  sum_arr_t         sum_next;
  avg_arr_t         avg_next;
  avg_arr_t         dist_next;
  cand_t            pair_next [NUM_PAIR];
  cand_t            mid_a, mid_b, best;
  logic [SUM_W-1:0] ul, u, ur, l, c, r, dl, d, dr;

  // Ready chain: a stage takes data when empty or when its data moves on
  assign s5_ready = !s5_valid || out_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Weighted window sums (kernel 1 2 1 / 2 4 2 / 1 2 1)
  always_comb begin
    ul = SUM_W'(px_up_left);
    u  = SUM_W'(px_up) << 1;
    ur = SUM_W'(px_up_right);
    l  = SUM_W'(px_left) << 1;
    c  = SUM_W'(px_center) << 2;
    r  = SUM_W'(px_right) << 1;
    dl = SUM_W'(px_down_left);
    d  = SUM_W'(px_down) << 1;
    dr = SUM_W'(px_down_right);
    sum_next[0] = ul + u + l + c;
    sum_next[1] = u + ur + c + r;
    sum_next[2] = l + c + dl + d;
    sum_next[3] = c + r + d + dr;
    sum_next[4] = ul + u + ur + l + c + r;
    sum_next[5] = l + c + r + dl + d + dr;
    sum_next[6] = u + ur + c + r + d + dr;
    sum_next[7] = ul + u + l + c + dl + d;
  end

  // Constant divides between stage 1 and stage 2
  swwf_avg u_avg (
    .sums (s1_sum),
    .avgs (avg_next)
  );

  // Absolute distance of each average from the centre pixel
  always_comb begin
    for (int w = 0; w < NUM_WIN; w++) begin
      dist_next[w] = (s2_avg[w] > s2_center) ? (s2_avg[w] - s2_center)
                                             : (s2_center - s2_avg[w]);
    end
  end

  // Pairwise pick; the lower index wins ties
  always_comb begin
    for (int p = 0; p < NUM_PAIR; p++) begin
      if (s3_dist[2*p+1] < s3_dist[2*p]) begin
        pair_next[p] = '{diff: s3_dist[2*p+1], avg: s3_avg[2*p+1],
                         idx: WIN_W'(2*p+1)};
      end else begin
        pair_next[p] = '{diff: s3_dist[2*p], avg: s3_avg[2*p],
                         idx: WIN_W'(2*p)};
      end
    end
  end

  // Final pick over the four survivors
  always_comb begin
    mid_a = (s4_cand[1].diff < s4_cand[0].diff) ? s4_cand[1] : s4_cand[0];
    mid_b = (s4_cand[3].diff < s4_cand[2].diff) ? s4_cand[3] : s4_cand[2];
    best  = (mid_b.diff < mid_a.diff) ? mid_b : mid_a;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= s4_valid;
    end
  end

  // Advance stage data; a stalled stage holds
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_sum    <= sum_next;
      s1_center <= px_center;
      s1_border <= on_border;
    end
    if (s2_ready) begin
      s2_avg    <= avg_next;
      s2_center <= s1_center;
      s2_border <= s1_border;
    end
    if (s3_ready) begin
      s3_avg    <= s2_avg;
      s3_dist   <= dist_next;
      s3_center <= s2_center;
      s3_border <= s2_border;
    end
    if (s4_ready) begin
      s4_cand   <= pair_next;
      s4_center <= s3_center;
      s4_border <= s3_border;
    end
    if (s5_ready) begin
      if (s4_border) begin
        s5_pixel  <= s4_center;
        s5_window <= '0;
      end else begin
        s5_pixel  <= best.avg;
        s5_window <= best.idx;
      end
    end
  end

  assign out_valid      = s5_valid;
  assign filtered_pixel = s5_pixel;
  assign chosen_window  = s5_window;

endmodule

`default_nettype wire

// File: sv/swwf_avg.sv
// ============================================================================
// swwf_avg
// Divides the eight window sums by their kernel totals with constant
// reciprocal multiplies (truncating, exact over the whole sum range).
// ============================================================================
`default_nettype none

module swwf_avg
  import swwf_pkg::*;
(
  input  sum_arr_t sums,
  output avg_arr_t avgs
);

  localparam int PROD_W = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod [NUM_WIN];

  // Multiply by the reciprocal and keep the integer part
  always_comb begin
    for (int w = 0; w < NUM_WIN; w++) begin
      if (w < NUM_QUAD) begin
        prod[w] = PROD_W'(sums[w]) * PROD_W'(RECIP_QUAD);
      end else begin
        prod[w] = PROD_W'(sums[w]) * PROD_W'(RECIP_HALF);
      end
      avgs[w] = prod[w][DIV_SHIFT +: PIX_W];
    end
  end

endmodule

`default_nettype wire
